// ===== rtl/ckspr_pkg.sv =====
package ckspr_pkg;

   // Operation codes carried on req_operation.
   localparam logic OP_LOAD    = 1'b0;
   localparam logic OP_COMPOSE = 1'b1;

   // Register indexes of the configuration port.
   typedef enum logic [2:0] {
      CSR_SPRITE_LEFT       = 3'd0,
      CSR_SPRITE_TOP        = 3'd1,
      CSR_SPRITE_COLUMNS    = 3'd2,
      CSR_SPRITE_ROWS       = 3'd3,
      CSR_TRANSPARENT_COLOR = 3'd4
   } csr_index_type;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 16;
   localparam int COLOR_WIDTH     = 16;

   // Compose transaction waiting on the sprite store read.
   typedef struct packed {
      logic [COLOR_WIDTH-1:0] scene_color;
      logic                   sprite_candidate;
   } read_stage_type;

endpackage

// ===== rtl/ckspr_scene.sv =====
module ckspr_scene (
   input  logic [8:0]                          x,
   input  logic [7:0]                          y,
   output logic [ckspr_pkg::COLOR_WIDTH-1:0]   color
);
   import ckspr_pkg::*;

   localparam logic [15:0] COLOR_SKY_TOP     = 16'h5D7F;
   localparam logic [15:0] COLOR_SKY_MID     = 16'h865F;
   localparam logic [15:0] COLOR_SKY_LOW     = 16'hB73F;
   localparam logic [15:0] COLOR_MOUNT_DARK  = 16'h4A69;
   localparam logic [15:0] COLOR_MOUNT_LIGHT = 16'h6B6D;
   localparam logic [15:0] COLOR_WALL_DARK   = 16'h4208;
   localparam logic [15:0] COLOR_WALL_LIGHT  = 16'h632C;
   localparam logic [15:0] COLOR_GROUND_TOP  = 16'h7BEF;
   localparam logic [15:0] COLOR_GROUND      = 16'h39E7;
   localparam logic [15:0] COLOR_GROUND_DARK = 16'h2104;
   localparam logic [15:0] COLOR_BLACK       = 16'h0000;

   localparam int PEAK_MOD_TALL  = 38;
   localparam int PEAK_MOD_SHORT = 28;
   localparam logic [7:0] MOUNT_BASE = 8'd148;

   typedef logic [63:0][5:0] peak_table_type;

   // Peak heights per 8-pixel column, indexed by x / 8.
   function automatic peak_table_type build_tall_peaks();
      peak_table_type t;
      for (int i = 0; i < 64; i++) begin
         t[i] = 6'(22 + ((i * 8 * 5) % PEAK_MOD_TALL));
      end
      return t;
   endfunction

   function automatic peak_table_type build_short_peaks();
      peak_table_type t;
      for (int i = 0; i < 64; i++) begin
         t[i] = 6'(14 + ((i * 8 * 7) % PEAK_MOD_SHORT));
      end
      return t;
   endfunction

   localparam peak_table_type PEAK_TALL  = build_tall_peaks();
   localparam peak_table_type PEAK_SHORT = build_short_peaks();

   logic [5:0] column;
   logic [7:0] tall_edge;
   logic [7:0] short_edge;

   assign column     = x[8:3];
   assign tall_edge  = MOUNT_BASE - {2'b00, PEAK_TALL[column]};
   assign short_edge = MOUNT_BASE - {2'b00, PEAK_SHORT[column]};

   always_comb begin
      priority if (y < 8'd48) begin
         color = COLOR_SKY_TOP;
      end else if (y < 8'd96) begin
         color = COLOR_SKY_MID;
      end else if (y < MOUNT_BASE) begin
         // The left half of each column shows the lighter, shorter peak.
         priority if (!x[2] && y >= short_edge) begin
            color = COLOR_MOUNT_LIGHT;
         end else if (y >= tall_edge) begin
            color = COLOR_MOUNT_DARK;
         end else begin
            color = COLOR_SKY_LOW;
         end
      end else if (y < 8'd182) begin
         priority if (y >= 8'd180) begin
            color = COLOR_BLACK;
         end else if (y < 8'd150 || x[4:1] == 4'd0) begin
            color = COLOR_WALL_LIGHT;
         end else begin
            color = COLOR_WALL_DARK;
         end
      end else if (y < 8'd188) begin
         color = COLOR_GROUND_TOP;
      end else if (y >= 8'd232) begin
         color = COLOR_GROUND_DARK;
      end else begin
         color = COLOR_GROUND;
      end
   end

endmodule

// ===== rtl/ckspr_store.sv =====
module ckspr_store #(
   parameter int Depth = 4096,
   localparam int AddrWidth = $clog2(Depth)
) (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [AddrWidth-1:0]                wr_addr,
   input  logic [ckspr_pkg::COLOR_WIDTH-1:0]   wr_data,
   input  logic                                rd_en,
   input  logic [AddrWidth-1:0]                rd_addr,
   output logic [ckspr_pkg::COLOR_WIDTH-1:0]   rd_data
);
   import ckspr_pkg::*;

   logic [COLOR_WIDTH-1:0] mem_ff [Depth];
   logic [COLOR_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/color_key_sprite_compositor.sv =====
// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_ready  operation, screen_x, screen_y, load_index,
//                                             load_color
// rsp_      out        rsp_valid / rsp_ready  pixel_color, from_sprite
// csr_      in         csr_write              csr_index, csr_data
//
// One transaction is accepted per cycle while req_ready is high. A compose result
// passes the sprite store read, then the key compare and color select, before it
// reaches the output register. A load writes the store at its acceptance edge.
// Reset clears the configuration registers and the pipeline valids; store contents
// stay undefined until loaded. A stalled rsp_ready holds at most two compose
// transactions in flight before req_ready drops.
module color_key_sprite_compositor #(
   parameter int SPRITE_MAX_PIXELS = 4096
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_valid,
   output logic                                       req_ready,
   input  logic                                       req_operation,
   input  logic [8:0]                                 req_screen_x,
   input  logic [7:0]                                 req_screen_y,
   input  logic [11:0]                                req_load_index,
   input  logic [15:0]                                req_load_color,
   output logic                                       rsp_valid,
   input  logic                                       rsp_ready,
   output logic [15:0]                                rsp_pixel_color,
   output logic                                       rsp_from_sprite,
   input  logic                                       csr_write,
   input  logic [ckspr_pkg::CSR_INDEX_WIDTH-1:0]      csr_index,
   input  logic [ckspr_pkg::CSR_DATA_WIDTH-1:0]       csr_data
);
   import ckspr_pkg::*;

   localparam int ADDR_WIDTH = $clog2(SPRITE_MAX_PIXELS);

   // Configuration registers.
   logic signed [9:0]      sprite_left_ff;
   logic signed [8:0]      sprite_top_ff;
   logic [6:0]             sprite_columns_ff;
   logic [6:0]             sprite_rows_ff;
   logic [COLOR_WIDTH-1:0] transparent_color_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sprite_left_ff       <= '0;
         sprite_top_ff        <= '0;
         sprite_columns_ff    <= '0;
         sprite_rows_ff       <= '0;
         transparent_color_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_SPRITE_LEFT:       sprite_left_ff       <= csr_data[9:0];
            CSR_SPRITE_TOP:        sprite_top_ff        <= csr_data[8:0];
            CSR_SPRITE_COLUMNS:    sprite_columns_ff    <= csr_data[6:0];
            CSR_SPRITE_ROWS:       sprite_rows_ff       <= csr_data[6:0];
            CSR_TRANSPARENT_COLOR: transparent_color_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Handshake and pipeline control.
   logic           read_valid_ff;
   logic           read_valid_in;
   read_stage_type read_stage_ff;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   logic [15:0]    rsp_color_ff;
   logic           rsp_from_sprite_ff;
   logic           out_advance;
   logic           req_accept;
   logic           compose;
   logic           load;

   assign out_advance = !rsp_valid_ff || rsp_ready;
   assign req_ready   = !read_valid_ff || out_advance;
   assign req_accept  = req_valid && req_ready;
   assign compose     = req_accept && req_operation == OP_COMPOSE;

   // Sprite rectangle test and store address for the requested pixel.
   logic signed [11:0]     dx;
   logic signed [10:0]     dy;
   logic                   in_window;
   logic [13:0]            pos;
   logic [31:0]            pos_wide;
   logic [31:0]            load_index_wide;
   logic                   pos_in_range;
   logic                   load_in_range;
   logic [COLOR_WIDTH-1:0] scene_color;
   logic [COLOR_WIDTH-1:0] store_data;

   assign dx = $signed({3'b000, req_screen_x}) - $signed({{2{sprite_left_ff[9]}}, sprite_left_ff});
   assign dy = $signed({3'b000, req_screen_y}) - $signed({{2{sprite_top_ff[8]}}, sprite_top_ff});
   assign in_window = !dx[11] && !dy[10] &&
                      (dx[10:0] < {4'd0, sprite_columns_ff}) &&
                      (dy[9:0] < {3'd0, sprite_rows_ff});
   assign pos = 14'(dy[6:0]) * 14'(sprite_columns_ff) + 14'(dx[6:0]);
   assign pos_wide        = 32'(pos);
   assign load_index_wide = 32'(req_load_index);
   assign pos_in_range    = pos_wide < 32'(SPRITE_MAX_PIXELS);
   assign load_in_range   = load_index_wide < 32'(SPRITE_MAX_PIXELS);
   assign load = req_accept && req_operation == OP_LOAD && load_in_range;

   ckspr_scene u_scene (
      .x     (req_screen_x),
      .y     (req_screen_y),
      .color (scene_color)
   );

   ckspr_store #(
      .Depth (SPRITE_MAX_PIXELS)
   ) u_store (
      .clock   (clock),
      .wr_en   (load),
      .wr_addr (load_index_wide[ADDR_WIDTH-1:0]),
      .wr_data (req_load_color),
      .rd_en   (compose),
      .rd_addr (pos_wide[ADDR_WIDTH-1:0]),
      .rd_data (store_data)
   );

   // A load lands in the store at its own acceptance edge, so any later compose
   // reads the new value without forwarding.
   always_comb begin
      if (compose) begin
         read_valid_in = 1'b1;
      end else if (out_advance) begin
         read_valid_in = 1'b0;
      end else begin
         read_valid_in = read_valid_ff;
      end
   end

   always_comb begin
      if (out_advance) begin
         rsp_valid_in = read_valid_ff;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         read_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         read_valid_ff <= read_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (compose) begin
         read_stage_ff.scene_color      <= scene_color;
         read_stage_ff.sprite_candidate <= in_window && pos_in_range;
      end
   end

   logic sprite_hit;
   assign sprite_hit = read_stage_ff.sprite_candidate && store_data != transparent_color_ff;

   always_ff @(posedge clock) begin
      if (out_advance && read_valid_ff) begin
         rsp_color_ff       <= sprite_hit ? store_data : read_stage_ff.scene_color;
         rsp_from_sprite_ff <= sprite_hit;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_color = rsp_color_ff;
   assign rsp_from_sprite = rsp_from_sprite_ff;

endmodule
